// ----- rtl/uadv_pkg.sv -----
// ----------------------------------------------------------------------------
// uadv_pkg
// Shared types, constants and fixed-point helpers of the upwind
// advection-diffusion stencil.
// ----------------------------------------------------------------------------
package uadv_pkg;

	localparam int DATA_W  = 32;
	localparam int COORD_W = 6;
	localparam int GSIZE_W = 7;
	localparam int REG_W   = 3;
	// signed stencil coordinate, holds -2 .. grid size + 2
	localparam int CW      = 9;
	localparam int NPTS    = 9;
	localparam int CNT_W   = 4;

	localparam int GRID_W_DEF = 64;
	localparam int GRID_H_DEF = 64;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_UINF_X   = 3'd0;
	localparam logic [REG_W-1:0] REG_UINF_Y   = 3'd1;
	localparam logic [REG_W-1:0] REG_ADV      = 3'd2;
	localparam logic [REG_W-1:0] REG_DIFF     = 3'd3;
	localparam logic [REG_W-1:0] REG_GRAV_X   = 3'd4;
	localparam logic [REG_W-1:0] REG_GRAV_Y   = 3'd5;
	localparam logic [REG_W-1:0] REG_GRID_W   = 3'd6;
	localparam logic [REG_W-1:0] REG_GRID_H   = 3'd7;

	// request codes
	localparam logic REQ_WRITE   = 1'b0;
	localparam logic REQ_COMPUTE = 1'b1;

	// stencil point slots, in fetch order
	localparam int P_C   = 0;
	localparam int P_XM2 = 1;
	localparam int P_XM1 = 2;
	localparam int P_XP1 = 3;
	localparam int P_XP2 = 4;
	localparam int P_YM2 = 5;
	localparam int P_YM1 = 6;
	localparam int P_YP1 = 7;
	localparam int P_YP2 = 8;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_CALC,
		S_DONE
	} state_t;

	// where a stencil point lies relative to the domain
	typedef enum logic [2:0] {
		SIDE_IN,
		SIDE_W,
		SIDE_E,
		SIDE_S,
		SIDE_N
	} side_t;

	// per-component inputs of the update unit
	typedef struct packed {
		logic signed [DATA_W-1:0] uc;
		logic signed [DATA_W-1:0] vc;
		logic signed [DATA_W-1:0] uinf_x;
		logic signed [DATA_W-1:0] uinf_y;
		logic signed [DATA_W-1:0] adv_factor;
		logic signed [DATA_W-1:0] diff_factor;
		logic signed [DATA_W-1:0] grav;
		logic signed [DATA_W-1:0] inv;
	} calc_in_t;

	// x offset of a stencil slot
	function automatic logic signed [2:0] off_x(input logic [CNT_W-1:0] k);
		logic signed [2:0] r;
		case (k)
			CNT_W'(P_XM2): r = -3'sd2;
			CNT_W'(P_XM1): r = -3'sd1;
			CNT_W'(P_XP1): r = 3'sd1;
			CNT_W'(P_XP2): r = 3'sd2;
			default:       r = 3'sd0;
		endcase
		return r;
	endfunction

	// y offset of a stencil slot
	function automatic logic signed [2:0] off_y(input logic [CNT_W-1:0] k);
		logic signed [2:0] r;
		case (k)
			CNT_W'(P_YM2): r = -3'sd2;
			CNT_W'(P_YM1): r = -3'sd1;
			CNT_W'(P_YP1): r = 3'sd1;
			CNT_W'(P_YP2): r = 3'sd2;
			default:       r = 3'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > 64'sd2147483647)
			r = 32'sh7fffffff;
		else if (x < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = x[DATA_W-1:0];
		return r;
	endfunction

	// Q32.32 product back to Q16.16, round half up
	function automatic logic signed [49:0] rnd16(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + 66'sd32768;
		return t[65:16];
	endfunction

endpackage

// ----- rtl/uadv_req_if.sv -----
// ----------------------------------------------------------------------------
// uadv_req_if
// Request channel: cell write or cell update transaction.
// ----------------------------------------------------------------------------
interface uadv_req_if import uadv_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [COORD_W-1:0]        cell_x;
	logic [COORD_W-1:0]        cell_y;
	logic signed [DATA_W-1:0]  u_in;
	logic signed [DATA_W-1:0]  v_in;
	logic signed [DATA_W-1:0]  inv_density;

	modport source (output valid, req_type, cell_x, cell_y, u_in, v_in, inv_density,
		input ready);
	modport sink (input valid, req_type, cell_x, cell_y, u_in, v_in, inv_density,
		output ready);
endinterface

// ----- rtl/uadv_rsp_if.sv -----
// ----------------------------------------------------------------------------
// uadv_rsp_if
// Response channel: updated cell velocity.
// ----------------------------------------------------------------------------
interface uadv_rsp_if import uadv_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DATA_W-1:0]  u_new;
	logic signed [DATA_W-1:0]  v_new;

	modport source (output valid, u_new, v_new, input ready);
	modport sink (input valid, u_new, v_new, output ready);
endinterface

// ----- rtl/uadv_cfg_if.sv -----
// ----------------------------------------------------------------------------
// uadv_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
interface uadv_cfg_if import uadv_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [REG_W-1:0]    index;
	logic [DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/upwind_advection_diffusion_stencil.sv -----
// ----------------------------------------------------------------------------
// upwind_advection_diffusion_stencil
// Velocity grid store with a third-order upwind advection-diffusion update.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg: register writes, always ready. Write only while the block is idle.
//  - req: a transaction either stores (u,v) into one cell (req_type 0) or
//    asks for the updated velocity of one cell (req_type 1).
//  - rsp: one transaction per update request, none for a store.
// Flow:
//  - A store writes the cell as it is accepted; the next request is taken in the following cycle.
//  - An update fetches its nine stencil cells, one per cycle, through the
//    single read port of the u/v memories, then runs a five-stage arithmetic
//    pipe; from the done state the response is loaded into the output
//    register and the block returns to idle for the next request. An update
//    for a cell outside the domain skips the fetch and the pipe and answers zero.
//  - One update is processed at a time; the response sits in an output
//    register, so the next request is taken while it waits.
// Reset: configuration returns to its defaults, control is cleared. Grid
// memory is not cleared; cells must be stored before they are read.
// When rsp stalls, the response is held and a finished update waits for it.
// ----------------------------------------------------------------------------
module upwind_advection_diffusion_stencil import uadv_pkg::*; #(
	parameter int GRID_W = GRID_W_DEF,
	parameter int GRID_H = GRID_H_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	uadv_cfg_if.sink  cfg,
	uadv_req_if.sink  req,
	uadv_rsp_if.source rsp
);

	localparam int DEPTH = GRID_W * GRID_H;
	localparam int AW    = $clog2(DEPTH);

	// configuration registers
	logic signed [DATA_W-1:0] uinf_x_q, uinf_y_q, adv_q, diff_q, grav_x_q, grav_y_q;
	logic [GSIZE_W-1:0]       grid_w_q, grid_h_q;

	// request and sequencer state
	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         cnt_q;
	logic [COORD_W-1:0]       x_q, y_q;
	logic signed [DATA_W-1:0] inv_q;
	logic                     zero_q;

	logic signed [CW-1:0]     w_eff, h_eff, px, py, cx, cy;
	side_t                    side;
	logic                     in_domain, req_acc, ram_we, issue;
	logic [AW-1:0]            waddr, raddr;
	logic [DATA_W-1:0]        rd_u, rd_v;

	logic                     rd_vld_s1;
	logic [CNT_W-1:0]         rd_k_s1;
	side_t                    rd_side_s1;
	logic signed [32:0]       bsum;
	logic                     ghost_zero;

	logic signed [DATA_W-1:0] pu_q [NPTS];
	logic signed [DATA_W-1:0] pv_q [NPTS];
	logic                     calc_start_q, done_u, done_v, last_rd;
	logic signed [DATA_W-1:0] res_u, res_v;
	calc_in_t                 ci_u, ci_v;

	logic                     out_vld_q, out_load;
	logic signed [DATA_W-1:0] u_out_q, v_out_q;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uinf_x_q <= '0;
			uinf_y_q <= '0;
			adv_q    <= '0;
			diff_q   <= '0;
			grav_x_q <= '0;
			grav_y_q <= '0;
			grid_w_q <= GSIZE_W'(64);
			grid_h_q <= GSIZE_W'(64);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_UINF_X: uinf_x_q <= cfg.data;
				REG_UINF_Y: uinf_y_q <= cfg.data;
				REG_ADV:    adv_q    <= cfg.data;
				REG_DIFF:   diff_q   <= cfg.data;
				REG_GRAV_X: grav_x_q <= cfg.data;
				REG_GRAV_Y: grav_y_q <= cfg.data;
				REG_GRID_W: grid_w_q <= cfg.data[GSIZE_W-1:0];
				REG_GRID_H: grid_h_q <= cfg.data[GSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective grid size, clamped to 1 .. GRID_W / GRID_H
	always_comb begin
		if (grid_w_q == '0)
			w_eff = CW'(1);
		else if (32'(grid_w_q) > GRID_W)
			w_eff = CW'(GRID_W);
		else
			w_eff = CW'(grid_w_q);
		if (grid_h_q == '0)
			h_eff = CW'(1);
		else if (32'(grid_h_q) > GRID_H)
			h_eff = CW'(GRID_H);
		else
			h_eff = CW'(grid_h_q);
	end

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign in_domain = (CW'(req.cell_x) < w_eff) && (CW'(req.cell_y) < h_eff);
	assign ram_we    = req_acc && (req.req_type == REQ_WRITE) && in_domain;
	assign waddr     = AW'(req.cell_y) * AW'(GRID_W) + AW'(req.cell_x);

	// stencil point address with ghost clamping
	always_comb begin
		px   = CW'(x_q) + CW'(off_x(cnt_q));
		py   = CW'(y_q) + CW'(off_y(cnt_q));
		cx   = px;
		cy   = py;
		side = SIDE_IN;
		if (px < CW'(0)) begin
			cx   = CW'(0);
			side = SIDE_W;
		end else if (px >= w_eff) begin
			cx   = w_eff - CW'(1);
			side = SIDE_E;
		end else if (py < CW'(0)) begin
			cy   = CW'(0);
			side = SIDE_S;
		end else if (py >= h_eff) begin
			cy   = h_eff - CW'(1);
			side = SIDE_N;
		end
	end

	assign raddr = AW'(cy) * AW'(GRID_W) + AW'(cx);
	assign issue = (state_q == S_FETCH) && (cnt_q < CNT_W'(NPTS));

	uadv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_u (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (req.u_in),
		.raddr (raddr),
		.rdata (rd_u)
	);

	uadv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_v (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (req.v_in),
		.raddr (raddr),
		.rdata (rd_v)
	);

	// ghost zeroing where the edge flow points inward
	always_comb begin
		bsum = '0;
		ghost_zero = 1'b0;
		case (rd_side_s1)
			SIDE_W: begin
				bsum = 33'($signed(rd_u)) + 33'(uinf_x_q);
				ghost_zero = bsum > 33'sd0;
			end
			SIDE_E: begin
				bsum = 33'($signed(rd_u)) + 33'(uinf_x_q);
				ghost_zero = bsum < 33'sd0;
			end
			SIDE_S: begin
				bsum = 33'($signed(rd_v)) + 33'(uinf_y_q);
				ghost_zero = bsum > 33'sd0;
			end
			SIDE_N: begin
				bsum = 33'($signed(rd_v)) + 33'(uinf_y_q);
				ghost_zero = bsum < 33'sd0;
			end
			default: ;
		endcase
	end

	assign last_rd = rd_vld_s1 && (rd_k_s1 == CNT_W'(NPTS - 1));

	// read tag pipeline and stencil capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1    <= 1'b0;
			calc_start_q <= 1'b0;
		end else begin
			rd_vld_s1    <= issue;
			calc_start_q <= last_rd;
		end
	end

	always_ff @(posedge clk) begin
		rd_k_s1    <= cnt_q;
		rd_side_s1 <= side;
		if (rd_vld_s1) begin
			pu_q[rd_k_s1[CNT_W-1:0]] <= ghost_zero ? '0 : $signed(rd_u);
			pv_q[rd_k_s1[CNT_W-1:0]] <= ghost_zero ? '0 : $signed(rd_v);
		end
	end

	// request registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			zero_q <= 1'b0;
		end else begin
			if (req_acc) begin
				cnt_q  <= '0;
				zero_q <= !in_domain;
			end else if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			x_q   <= req.cell_x;
			y_q   <= req.cell_y;
			inv_q <= req.inv_density;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_acc && req.req_type == REQ_COMPUTE)
					state_d = in_domain ? S_FETCH : S_DONE;
			end
			S_FETCH: begin
				if (last_rd)
					state_d = S_CALC;
			end
			S_CALC: begin
				if (done_u)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// update units, one per component
	always_comb begin
		ci_u.uc          = pu_q[P_C];
		ci_u.vc          = pv_q[P_C];
		ci_u.uinf_x      = uinf_x_q;
		ci_u.uinf_y      = uinf_y_q;
		ci_u.adv_factor  = adv_q;
		ci_u.diff_factor = diff_q;
		ci_u.grav        = grav_x_q;
		ci_u.inv         = inv_q;
		ci_v             = ci_u;
		ci_v.grav        = grav_y_q;
	end

	uadv_calc u_calc_u (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start_q),
		.ci     (ci_u),
		.pts    (pu_q),
		.result (res_u),
		.done   (done_u)
	);

	uadv_calc u_calc_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start_q),
		.ci     (ci_v),
		.pts    (pv_q),
		.result (res_v),
		.done   (done_v)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_load)
			out_vld_q <= 1'b1;
		else if (rsp.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			u_out_q <= zero_q ? '0 : res_u;
			v_out_q <= zero_q ? '0 : res_v;
		end
	end

	assign rsp.valid = out_vld_q;
	assign rsp.u_new = u_out_q;
	assign rsp.v_new = v_out_q;

`ifndef SYNTHESIS
	a_store_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_IDLE)
		else $error("grid store outside idle");
	a_units_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		done_u == done_v)
		else $error("update units out of step");
	a_done_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		done_u |-> state_q == S_CALC)
		else $error("update finished outside calc state");
	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FETCH |-> cnt_q <= CNT_W'(NPTS))
		else $error("stencil fetch counter overran");
`endif

endmodule

// ----- rtl/uadv_ram.sv -----
// ----------------------------------------------------------------------------
// uadv_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module uadv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/uadv_calc.sv -----
// ----------------------------------------------------------------------------
// uadv_calc
// Five-stage update of one velocity component from its stencil points.
// ----------------------------------------------------------------------------
module uadv_calc import uadv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  calc_in_t                 ci,
	input  logic signed [DATA_W-1:0] pts [NPTS],
	output logic signed [DATA_W-1:0] result,
	output logic                     done
);

	// third-order upwind difference, exact
	function automatic logic signed [36:0] upwind(input logic pos,
		input logic signed [DATA_W-1:0] m2, input logic signed [DATA_W-1:0] m1,
		input logic signed [DATA_W-1:0] c, input logic signed [DATA_W-1:0] p1,
		input logic signed [DATA_W-1:0] p2);
		logic signed [36:0] r;
		if (pos)
			r = 37'sd2 * 37'(p1) + 37'sd3 * 37'(c) - 37'sd6 * 37'(m1) + 37'(m2);
		else
			r = 37'sd6 * 37'(p1) - 37'(p2) - 37'sd3 * 37'(c) - 37'sd2 * 37'(m1);
		return r;
	endfunction

	logic [4:0] vld_q;

	logic signed [32:0]       bu33, bv33;
	logic signed [DATA_W-1:0] bu_s1, bv_s1, dx_s1, dy_s1, lap_s1, c_s1;
	logic signed [33:0]       gm_s1;
	logic signed [63:0]       pa_s2, pb_s2;
	logic signed [65:0]       pg_s2;
	logic signed [DATA_W-1:0] lap_s2, c_s2, lap_s3, c_s3, adv_s3, c_s4;
	logic signed [49:0]       tg_s3, tg_s4;
	logic signed [63:0]       pa_s4, pd_s4;
	logic signed [DATA_W-1:0] res_s5;

	assign bu33 = 33'(ci.uc) + 33'(ci.uinf_x);
	assign bv33 = 33'(ci.vc) + 33'(ci.uinf_y);

	// stage valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[3:0], start};
	end

	// datapath stages
	always_ff @(posedge clk) begin
		// s1: advecting velocity, upwind differences, Laplacian
		bu_s1  <= sat32(64'(bu33));
		bv_s1  <= sat32(64'(bv33));
		dx_s1  <= sat32(64'(upwind(bu33 > 33'sd0, pts[P_XM2], pts[P_XM1], pts[P_C],
			pts[P_XP1], pts[P_XP2])));
		dy_s1  <= sat32(64'(upwind(bv33 > 33'sd0, pts[P_YM2], pts[P_YM1], pts[P_C],
			pts[P_YP1], pts[P_YP2])));
		lap_s1 <= sat32(64'(pts[P_XP1]) + 64'(pts[P_YP1]) + 64'(pts[P_XM1])
			+ 64'(pts[P_YM1]) - 64'sd4 * 64'(pts[P_C]));
		gm_s1  <= 34'sd65536 - 34'(ci.inv);
		c_s1   <= pts[P_C];
		// s2: advection and gravity products
		pa_s2  <= bu_s1 * dx_s1;
		pb_s2  <= bv_s1 * dy_s1;
		pg_s2  <= 66'(ci.grav) * 66'(gm_s1);
		lap_s2 <= lap_s1;
		c_s2   <= c_s1;
		// s3: advective sum, rounded gravity term
		adv_s3 <= sat32(64'(rnd16(66'(pa_s2))) + 64'(rnd16(66'(pb_s2))));
		tg_s3  <= rnd16(pg_s2);
		lap_s3 <= lap_s2;
		c_s3   <= c_s2;
		// s4: scale by the factors
		pa_s4  <= ci.adv_factor * adv_s3;
		pd_s4  <= ci.diff_factor * lap_s3;
		tg_s4  <= tg_s3;
		c_s4   <= c_s3;
		// s5: final sum, saturated
		res_s5 <= sat32(64'(c_s4) + 64'(rnd16(66'(pa_s4))) + 64'(rnd16(66'(pd_s4)))
			+ 64'(tg_s4));
	end

	assign result = res_s5;
	assign done   = vld_q[4];

endmodule

// ----- test/upwind_advection_diffusion_stencil_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// upwind_advection_diffusion_stencil_test
// Stores a band of cells, then runs directed and random store/update
// transactions under several register settings with random idle on both
// channels; every response is checked against an in-bench stencil predictor.
// ----------------------------------------------------------------------------
module upwind_advection_diffusion_stencil_test;
	import uadv_pkg::*;

	localparam int GW = 64;
	localparam int GH = 64;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [DATA_W-1:0] u;
		logic signed [DATA_W-1:0] v;
	} vel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	uadv_cfg_if cfg();
	uadv_req_if req();
	uadv_rsp_if rsp();

	upwind_advection_diffusion_stencil #(.GRID_W(GW), .GRID_H(GH)) uut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .req(req), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// predictor state: grid, written marks and register copies
	logic [31:0] grid_u_m [GW*GH];
	logic [31:0] grid_v_m [GW*GH];
	bit written_m [GW*GH];
	longint uinf_x_m, uinf_y_m, adv_m, diff_m, grav_x_m, grav_y_m;
	logic [6:0] width_m, height_m;

	vel_t pending_vel[$];
	int mismatches = 0;
	int errors = 0;
	int cycles = 0;
	int rsp_stall = 0;
	bit idle_on = 1'b0;

	function automatic longint sat32_m(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Q16.16 product, round half up
	function automatic longint qmul(longint a, longint b);
		return (a * b + 32768) >>> 16;
	endfunction

	function automatic longint grid_at(int x, int y, int comp);
		int i;
		i = y * GW + x;
		return comp ? longint'($signed(grid_v_m[i])) : longint'($signed(grid_u_m[i]));
	endfunction

	// effective domain size from a size register
	function automatic int eff_dim(logic [6:0] r, int lim);
		return (r == 0) ? 1 : (r > lim) ? lim : int'(r);
	endfunction

	// stencil point with ghost cells copied from edge, zeroed on inflow side
	function automatic longint stencil_pt(int x, int y, int comp, int w, int h);
		if (x < 0) return (grid_at(0, y, 0) + uinf_x_m > 0) ? 0 : grid_at(0, y, comp);
		if (x >= w) return (grid_at(w - 1, y, 0) + uinf_x_m < 0) ? 0 : grid_at(w - 1, y, comp);
		if (y < 0) return (grid_at(x, 0, 1) + uinf_y_m > 0) ? 0 : grid_at(x, 0, comp);
		if (y >= h) return (grid_at(x, h - 1, 1) + uinf_y_m < 0) ? 0 : grid_at(x, h - 1, comp);
		return grid_at(x, y, comp);
	endfunction

	function automatic longint upwind_diff(bit pos, longint m2, longint m1, longint c,
			longint p1, longint p2);
		if (pos) return 2 * p1 + 3 * c - 6 * m1 + m2;
		return -p2 + 6 * p1 - 3 * c - 2 * m1;
	endfunction

	function automatic logic signed [31:0] advect_cell(int x, int y, int comp, int w, int h,
			longint inv);
		longint c, xm2, xm1, xp1, xp2, ym2, ym1, yp1, yp2, bu, bv, ddx, ddy, adv, lap, g;
		c   = stencil_pt(x, y, comp, w, h);
		xm2 = stencil_pt(x - 2, y, comp, w, h);
		xm1 = stencil_pt(x - 1, y, comp, w, h);
		xp1 = stencil_pt(x + 1, y, comp, w, h);
		xp2 = stencil_pt(x + 2, y, comp, w, h);
		ym2 = stencil_pt(x, y - 2, comp, w, h);
		ym1 = stencil_pt(x, y - 1, comp, w, h);
		yp1 = stencil_pt(x, y + 1, comp, w, h);
		yp2 = stencil_pt(x, y + 2, comp, w, h);
		bu  = grid_at(x, y, 0) + uinf_x_m;
		bv  = grid_at(x, y, 1) + uinf_y_m;
		ddx = sat32_m(upwind_diff(bu > 0, xm2, xm1, c, xp1, xp2));
		ddy = sat32_m(upwind_diff(bv > 0, ym2, ym1, c, yp1, yp2));
		adv = sat32_m(qmul(sat32_m(bu), ddx) + qmul(sat32_m(bv), ddy));
		lap = sat32_m(xp1 + yp1 + xm1 + ym1 - 4 * c);
		g   = comp ? grav_y_m : grav_x_m;
		return 32'(sat32_m(c + qmul(adv_m, adv) + qmul(diff_m, lap) + qmul(g, 65536 - inv)));
	endfunction

	// apply one accepted transaction to the predictor
	function automatic void predict_req(logic rt, int x, int y, logic [31:0] u, logic [31:0] v,
			logic [31:0] inv);
		int w, h;
		bit in_dom;
		vel_t e;
		w = eff_dim(width_m, GW);
		h = eff_dim(height_m, GH);
		in_dom = (x < w) && (y < h);
		if (rt == REQ_WRITE) begin
			if (in_dom) begin
				grid_u_m[y * GW + x] = u;
				grid_v_m[y * GW + x] = v;
				written_m[y * GW + x] = 1'b1;
			end
			return;
		end
		e.u = 0;
		e.v = 0;
		if (in_dom) begin
			e.u = advect_cell(x, y, 0, w, h, longint'($signed(inv)));
			e.v = advect_cell(x, y, 1, w, h, longint'($signed(inv)));
		end
		pending_vel.push_back(e);
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// response side ready with random stalls
	always @(negedge clk) begin
		if (rsp_stall > 0) begin
			rsp_stall <= rsp_stall - 1;
			rsp.ready <= 1'b0;
		end else
			rsp.ready <= 1'b1;
	end

	// response checker
	always @(posedge clk) begin
		vel_t e;
		if (rsp.valid && rsp.ready) begin
			rsp_stall <= idle_on ? $urandom_range(0, 16) : 0;
			if (pending_vel.size() == 0) begin
				errors++;
				$display("unexpected response u=%h v=%h", rsp.u_new, rsp.v_new);
			end else begin
				e = pending_vel.pop_front();
				if (e.u !== rsp.u_new || e.v !== rsp.v_new) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected u=%h v=%h, got u=%h v=%h",
							e.u, e.v, rsp.u_new, rsp.v_new);
				end
			end
		end
	end

	task automatic send_req(logic rt, int x, int y, logic [31:0] u, logic [31:0] v,
			logic [31:0] inv);
		int gap;
		gap = idle_on ? $urandom_range(0, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid       <= 1'b1;
		req.req_type    <= rt;
		req.cell_x      <= x[5:0];
		req.cell_y      <= y[5:0];
		req.u_in        <= u;
		req.v_in        <= v;
		req.inv_density <= inv;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_req(rt, x, y, u, v, inv);
	endtask

	// stop sending and wait for every outstanding response
	task automatic drain;
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_vel.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_UINF_X: uinf_x_m = longint'($signed(val));
			REG_UINF_Y: uinf_y_m = longint'($signed(val));
			REG_ADV:    adv_m    = longint'($signed(val));
			REG_DIFF:   diff_m   = longint'($signed(val));
			REG_GRAV_X: grav_x_m = longint'($signed(val));
			REG_GRAV_Y: grav_y_m = longint'($signed(val));
			REG_GRID_W: width_m  = val[6:0];
			REG_GRID_H: height_m = val[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// a Q16.16 value: extremes, small magnitudes or any pattern
	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3, 4: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			5: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
			default: return $urandom();
		endcase
	endfunction

	// store any cell that the stencil of (x,y) reads and that holds no data yet
	task automatic ensure_stencil(int x, int y);
		int ox[9] = '{0, -2, -1, 1, 2, 0, 0, 0, 0};
		int oy[9] = '{0, 0, 0, 0, 0, -2, -1, 1, 2};
		int w, h, cx, cy;
		w = eff_dim(width_m, GW);
		h = eff_dim(height_m, GH);
		if (x >= w || y >= h)
			return;
		for (int k = 0; k < 9; k++) begin
			cx = x + ox[k];
			cy = y + oy[k];
			cx = (cx < 0) ? 0 : (cx >= w) ? w - 1 : cx;
			cy = (cy < 0) ? 0 : (cy >= h) ? h - 1 : cy;
			if (!written_m[cy * GW + cx])
				send_req(REQ_WRITE, cx, cy, rand_q(), rand_q(), 32'h0);
		end
	endtask

	// update request on a cell whose stencil holds stored data
	task automatic send_compute(int x, int y, logic [31:0] inv);
		ensure_stencil(x, y);
		send_req(REQ_COMPUTE, x, y, $urandom(), $urandom(), inv);
	endtask

	// coordinate near an edge of a domain of the given size
	function automatic int pick_coord(int dim);
		int d;
		d = (dim < 1) ? 1 : (dim > 64) ? 64 : dim;
		if (d <= 8) return $urandom_range(0, d - 1);
		if ($urandom_range(0, 1) == 0) return $urandom_range(0, 3);
		return $urandom_range(d - 4, d - 1);
	endfunction

	task automatic set_physics(logic [31:0] ux, logic [31:0] uy, logic [31:0] adv,
			logic [31:0] dif, logic [31:0] gx, logic [31:0] gy);
		write_reg(REG_UINF_X, ux);
		write_reg(REG_UINF_Y, uy);
		write_reg(REG_ADV, adv);
		write_reg(REG_DIFF, dif);
		write_reg(REG_GRAV_X, gx);
		write_reg(REG_GRAV_Y, gy);
	endtask

	// back-to-back stores along the two bottom rows
	task automatic test_fill_grid;
		idle_on = 1'b0;
		for (int y = 0; y < 2; y++)
			for (int x = 0; x < GW; x++)
				send_req(REQ_WRITE, x, y, rand_q(), rand_q(), 32'h0);
		drain();
	endtask

	// corners, edges and extreme data
	task automatic test_directed;
		set_physics(32'h00008000, 32'hffff8000, 32'hffffd555, 32'h00001000,
			32'h0009cf5c, 32'hfff6309a);
		send_req(REQ_WRITE, 0, 0, 32'h7fffffff, 32'h80000000, 32'h0);
		send_req(REQ_WRITE, 63, 63, 32'h80000000, 32'h7fffffff, 32'h0);
		send_req(REQ_WRITE, 1, 0, 32'h00010000, 32'hffff0000, 32'h0);
		send_compute(0, 0, 32'h00010000);
		send_compute(63, 63, 32'h7fffffff);
		send_compute(1, 0, 32'h80000000);
		send_compute(0, 63, 32'h0);
		send_compute(63, 0, 32'hffffffff);
		send_compute(32, 1, 32'h00008000);
		send_compute(1, 62, 32'h00020000);
		drain();
		// saturating coefficients everywhere
		set_physics(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff);
		send_compute(0, 0, 32'h80000000);
		send_compute(63, 63, 32'h7fffffff);
		send_compute(2, 30, 32'h0);
		drain();
	endtask

	// tiny and out-of-range domain sizes, including outside cells
	task automatic test_grid_sizes;
		write_reg(REG_GRID_W, 32'd1);
		write_reg(REG_GRID_H, 32'd1);
		send_compute(0, 0, 32'h00010000);
		send_compute(1, 0, 32'h00010000);
		send_req(REQ_WRITE, 5, 5, 32'h12345678, 32'h9abcdef0, 32'h0);
		send_compute(63, 63, 32'h0);
		drain();
		write_reg(REG_GRID_W, 32'd0);
		write_reg(REG_GRID_H, 32'd127);
		send_compute(0, 40, 32'h0);
		send_compute(1, 40, 32'h0);
		drain();
		write_reg(REG_GRID_W, 32'd5);
		write_reg(REG_GRID_H, 32'd3);
		send_compute(4, 2, 32'h0);
		send_compute(2, 1, 32'h0);
		send_compute(5, 2, 32'h0);
		drain();
	endtask

	// random phases: new registers, then mixed stores and updates
	task automatic test_random;
		int wdim, hdim, x, y;
		for (int ph = 0; ph < 16; ph++) begin
			set_physics(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
			case (ph % 5)
				0: begin wdim = 64; hdim = 64; end
				1: begin wdim = 1; hdim = $urandom_range(1, 8); end
				2: begin wdim = $urandom_range(65, 127); hdim = $urandom_range(0, 6); end
				default: begin wdim = $urandom_range(1, 64); hdim = $urandom_range(1, 64); end
			endcase
			write_reg(REG_GRID_W, 32'(wdim));
			write_reg(REG_GRID_H, 32'(hdim));
			idle_on = (ph % 4) != 3;
			for (int n = 0; n < 40; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					x = $urandom_range(0, 63);
					y = $urandom_range(0, 63);
				end else begin
					x = pick_coord(wdim);
					y = pick_coord(hdim);
				end
				if ($urandom_range(0, 9) < 4)
					send_req(REQ_WRITE, x, y, rand_q(), rand_q(), $urandom());
				else
					send_compute(x, y, rand_q());
			end
			drain();
		end
	endtask

	initial begin
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		req.valid = 1'b0;
		req.req_type = REQ_WRITE;
		req.cell_x = '0;
		req.cell_y = '0;
		req.u_in = '0;
		req.v_in = '0;
		req.inv_density = '0;
		rsp.ready = 1'b0;
		uinf_x_m = 0;
		uinf_y_m = 0;
		adv_m = 0;
		diff_m = 0;
		grav_x_m = 0;
		grav_y_m = 0;
		width_m = 7'd64;
		height_m = 7'd64;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_fill_grid();
		idle_on = 1'b1;
		test_directed();
		test_grid_sizes();
		test_random();

		drain();
		if (errors == 0 && mismatches == 0 && pending_vel.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/uadv_pkg.sv
rtl/uadv_req_if.sv
rtl/uadv_rsp_if.sv
rtl/uadv_cfg_if.sv
rtl/uadv_ram.sv
rtl/uadv_calc.sv
rtl/upwind_advection_diffusion_stencil.sv
test/upwind_advection_diffusion_stencil_test.sv
